// ===== rtl/lwbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_pkg
// shared types and codes for the lru write-back block cache controller
// ----------------------------------------------------------------------------
package lwbc_pkg;

  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SYNC   = 2'd3;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_WB     = 2'd1;
  localparam logic [1:0] KIND_FILL   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WB,
    ST_FILL,
    ST_STAT
  } state_t;

  // update broadcast to every slot cell
  typedef struct packed {
    logic en;
    logic drop;
    logic load;
    logic bump_all;
    logic dirty_set;
    logic dirty_clr;
  } upd_ctl_t;

  // flags passed along the cell chain
  typedef struct packed {
    logic hit;
    logic hit_dirty;
    logic vic;
    logic vic_dirty;
    logic head_valid;
  } chain_flags_t;

endpackage

// ===== rtl/lwbc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_cell
// one cache slot: tag, valid, dirty, recency rank and free link, with its
// contribution merged into the lookup chain from its left neighbor
// ----------------------------------------------------------------------------
module lwbc_cell #(
  parameter int IDX       = 0,
  parameter int NUM_SLOTS = 16,
  parameter int ID_BITS   = 32,
  parameter int IDX_W     = 4,
  parameter int LINK_W    = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lwbc_pkg::upd_ctl_t      ctl,
  input  logic [IDX_W-1:0]        upd_slot,
  input  logic [IDX_W-1:0]        upd_rank,
  input  logic [ID_BITS-1:0]      req_id,
  input  logic [LINK_W-1:0]       free_head,
  input  lwbc_pkg::chain_flags_t  fl_in,
  input  logic [IDX_W-1:0]        hit_idx_in,
  input  logic [IDX_W-1:0]        hit_rank_in,
  input  logic [IDX_W-1:0]        vic_idx_in,
  input  logic [ID_BITS-1:0]      vic_tag_in,
  input  logic [LINK_W-1:0]       head_link_in,
  output lwbc_pkg::chain_flags_t  fl_out,
  output logic [IDX_W-1:0]        hit_idx_out,
  output logic [IDX_W-1:0]        hit_rank_out,
  output logic [IDX_W-1:0]        vic_idx_out,
  output logic [ID_BITS-1:0]      vic_tag_out,
  output logic [LINK_W-1:0]       head_link_out
);

  localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(IDX);
  localparam logic [IDX_W-1:0]  LRU_RANK = IDX_W'(NUM_SLOTS - 1);
  localparam logic [LINK_W-1:0] MY_HEAD  = LINK_W'(IDX);
  localparam logic [LINK_W-1:0] RST_LINK = LINK_W'(IDX + 1);

  logic [ID_BITS-1:0] tag;
  logic               valid;
  logic               dirty;
  logic [IDX_W-1:0]   rank;
  logic [LINK_W-1:0]  link;

  logic match;
  logic victim;
  logic at_head;
  logic sel;

  assign match   = valid && (tag == req_id);
  assign victim  = valid && (rank == LRU_RANK);
  assign at_head = (free_head == MY_HEAD);
  assign sel     = (upd_slot == MY_IDX);

  always_comb begin
    fl_out.hit        = fl_in.hit | match;
    fl_out.hit_dirty  = fl_in.hit_dirty | (match & dirty);
    fl_out.vic        = fl_in.vic | victim;
    fl_out.vic_dirty  = fl_in.vic_dirty | (victim & dirty);
    fl_out.head_valid = fl_in.head_valid | (at_head & valid);
    hit_idx_out   = hit_idx_in | (match ? MY_IDX : '0);
    hit_rank_out  = hit_rank_in | (match ? rank : '0);
    vic_idx_out   = vic_idx_in | (victim ? MY_IDX : '0);
    vic_tag_out   = vic_tag_in | (victim ? tag : '0);
    head_link_out = head_link_in | (at_head ? link : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      rank  <= '0;
      link  <= RST_LINK;
    end else if (ctl.en) begin
      if (sel) begin
        if (ctl.drop) begin
          valid <= 1'b0;
          dirty <= 1'b0;
          rank  <= '0;
          link  <= free_head;
        end else begin
          rank <= '0;
          if (ctl.load) begin
            valid <= 1'b1;
          end
          if (ctl.dirty_set) begin
            dirty <= 1'b1;
          end
          if (ctl.dirty_clr) begin
            dirty <= 1'b0;
          end
        end
      end else if (valid) begin
        if (ctl.drop) begin
          if (rank > upd_rank) begin
            rank <= rank - 1'b1;
          end
        end else if (ctl.bump_all || (rank < upd_rank)) begin
          rank <= rank + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.load && sel) begin
      tag <= req_id;
    end
  end

endmodule

// ===== rtl/lwbc_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_row
// row of slot cells chained left to right; the last cell gives the lookup
// ----------------------------------------------------------------------------
module lwbc_row #(
  parameter int NUM_SLOTS = 16,
  parameter int ID_BITS   = 32,
  parameter int IDX_W     = 4,
  parameter int LINK_W    = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lwbc_pkg::upd_ctl_t      ctl,
  input  logic [IDX_W-1:0]        upd_slot,
  input  logic [IDX_W-1:0]        upd_rank,
  input  logic [ID_BITS-1:0]      req_id,
  input  logic [LINK_W-1:0]       free_head,
  output lwbc_pkg::chain_flags_t  flags,
  output logic [IDX_W-1:0]        hit_idx,
  output logic [IDX_W-1:0]        hit_rank,
  output logic [IDX_W-1:0]        vic_idx,
  output logic [ID_BITS-1:0]      vic_tag,
  output logic [LINK_W-1:0]       head_link
);

  lwbc_pkg::chain_flags_t fl_c   [NUM_SLOTS+1];
  logic [IDX_W-1:0]       hidx_c [NUM_SLOTS+1];
  logic [IDX_W-1:0]       hrank_c[NUM_SLOTS+1];
  logic [IDX_W-1:0]       vidx_c [NUM_SLOTS+1];
  logic [ID_BITS-1:0]     vtag_c [NUM_SLOTS+1];
  logic [LINK_W-1:0]      link_c [NUM_SLOTS+1];

  assign fl_c[0]    = '0;
  assign hidx_c[0]  = '0;
  assign hrank_c[0] = '0;
  assign vidx_c[0]  = '0;
  assign vtag_c[0]  = '0;
  assign link_c[0]  = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    lwbc_cell #(
      .IDX       (i),
      .NUM_SLOTS (NUM_SLOTS),
      .ID_BITS   (ID_BITS),
      .IDX_W     (IDX_W),
      .LINK_W    (LINK_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .upd_slot      (upd_slot),
      .upd_rank      (upd_rank),
      .req_id        (req_id),
      .free_head     (free_head),
      .fl_in         (fl_c[i]),
      .hit_idx_in    (hidx_c[i]),
      .hit_rank_in   (hrank_c[i]),
      .vic_idx_in    (vidx_c[i]),
      .vic_tag_in    (vtag_c[i]),
      .head_link_in  (link_c[i]),
      .fl_out        (fl_c[i+1]),
      .hit_idx_out   (hidx_c[i+1]),
      .hit_rank_out  (hrank_c[i+1]),
      .vic_idx_out   (vidx_c[i+1]),
      .vic_tag_out   (vtag_c[i+1]),
      .head_link_out (link_c[i+1])
    );
  end

  assign flags     = fl_c[NUM_SLOTS];
  assign hit_idx   = hidx_c[NUM_SLOTS];
  assign hit_rank  = hrank_c[NUM_SLOTS];
  assign vic_idx   = vidx_c[NUM_SLOTS];
  assign vic_tag   = vtag_c[NUM_SLOTS];
  assign head_link = link_c[NUM_SLOTS];

endmodule

// ===== rtl/lru_writeback_block_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_writeback_block_cache
// fully associative write-back block cache controller with lru replacement
// ----------------------------------------------------------------------------
// One request is handled at a time: the transaction is taken, then the
// lookup runs through the row of slot cells (tag match, lru victim and free
// list head all merged along the chain), then each result is sent through the
// output register (optional writeback command, optional fill command, final
// status with tlast), waiting while the result side stalls. Slot state is
// updated in the cycle the status is sent, and the next request is taken
// while that status still waits.
module lru_writeback_block_cache #(
  parameter int NUM_SLOTS = 16,
  parameter int ID_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // request id[31:0]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // slot[3:0], blk[35:4], ok[36], zero[39:37]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LINK_W = $clog2(NUM_SLOTS + 1);
  localparam logic [LINK_W-1:0] END_LINK = LINK_W'(NUM_SLOTS);
  localparam logic [IDX_W-1:0]  LRU_RANK = IDX_W'(NUM_SLOTS - 1);

  lwbc_pkg::state_t state;
  lwbc_pkg::state_t state_next;

  logic [1:0]         req_op;
  logic [ID_BITS-1:0] req_id;
  logic [LINK_W-1:0]  free_head;

  lwbc_pkg::chain_flags_t c_flags;
  logic [IDX_W-1:0]       c_hit_idx;
  logic [IDX_W-1:0]       c_hit_rank;
  logic [IDX_W-1:0]       c_vic_idx;
  logic [ID_BITS-1:0]     c_vic_tag;
  logic [LINK_W-1:0]      c_head_link;

  logic                free_ok;
  logic [IDX_W-1:0]    d_slot;
  logic [IDX_W-1:0]    d_rank;
  lwbc_pkg::upd_ctl_t  d_ctl;
  logic                d_wb;
  logic [31:0]         d_wb_blk;
  logic                d_fill;
  logic                d_ok;
  logic                d_pop;
  logic                d_free_push;

  logic [IDX_W-1:0]    r_slot;
  logic [IDX_W-1:0]    r_rank;
  lwbc_pkg::upd_ctl_t  r_ctl;
  logic                r_wb;
  logic [31:0]         r_wb_blk;
  logic                r_fill;
  logic                r_ok;
  logic                r_pop;
  logic                r_free_push;

  logic                out_free;
  logic                push;
  logic                apply;
  logic [1:0]          push_kind;
  logic [3:0]          push_slot;
  logic [31:0]         push_blk;
  logic                push_ok;
  logic                push_last;
  lwbc_pkg::upd_ctl_t  cell_ctl;

  logic [1:0]          out_kind;
  logic [3:0]          out_slot;
  logic [31:0]         out_blk;
  logic                out_ok;
  logic                out_last;

  assign s_axis_tready = (state == lwbc_pkg::ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign cell_ctl      = apply ? r_ctl : '0;

  lwbc_row #(
    .NUM_SLOTS (NUM_SLOTS),
    .ID_BITS   (ID_BITS),
    .IDX_W     (IDX_W),
    .LINK_W    (LINK_W)
  ) u_row (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cell_ctl),
    .upd_slot  (r_slot),
    .upd_rank  (r_rank),
    .req_id    (req_id),
    .free_head (free_head),
    .flags     (c_flags),
    .hit_idx   (c_hit_idx),
    .hit_rank  (c_hit_rank),
    .vic_idx   (c_vic_idx),
    .vic_tag   (c_vic_tag),
    .head_link (c_head_link)
  );

  // lookup decision
  always_comb begin
    free_ok     = (free_head < END_LINK) && !c_flags.head_valid;
    d_slot      = '0;
    d_rank      = c_hit_rank;
    d_ctl       = '0;
    d_wb        = 1'b0;
    d_wb_blk    = 32'(req_id);
    d_fill      = 1'b0;
    d_ok        = 1'b0;
    d_pop       = 1'b0;
    d_free_push = 1'b0;
    if (req_op == lwbc_pkg::OP_UPSERT) begin
      d_ok            = 1'b1;
      d_ctl.en        = 1'b1;
      d_ctl.dirty_set = 1'b1;
      if (c_flags.hit) begin
        d_slot = c_hit_idx;
      end else if (free_ok) begin
        d_slot         = free_head[IDX_W-1:0];
        d_ctl.bump_all = 1'b1;
        d_ctl.load     = 1'b1;
        d_fill         = 1'b1;
        d_pop          = 1'b1;
      end else begin
        d_fill     = 1'b1;
        d_ctl.load = 1'b1;
        if (c_flags.vic) begin
          d_slot   = c_vic_idx;
          d_rank   = LRU_RANK;
          d_wb     = c_flags.vic_dirty;
          d_wb_blk = 32'(c_vic_tag);
        end else begin
          d_ctl.bump_all = 1'b1;
        end
      end
    end else if (c_flags.hit) begin
      d_ok     = 1'b1;
      d_slot   = c_hit_idx;
      d_ctl.en = 1'b1;
      case (req_op)
        lwbc_pkg::OP_REMOVE: begin
          d_ctl.drop  = 1'b1;
          d_wb        = c_flags.hit_dirty;
          d_free_push = 1'b1;
        end
        lwbc_pkg::OP_SYNC: begin
          d_ctl.dirty_clr = 1'b1;
          d_wb            = c_flags.hit_dirty;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    apply      = 1'b0;
    push_kind  = lwbc_pkg::KIND_STATUS;
    push_slot  = 4'(r_slot);
    push_blk   = 32'(req_id);
    push_ok    = 1'b0;
    push_last  = 1'b0;
    case (state)
      lwbc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = lwbc_pkg::ST_LOOK;
        end
      end
      lwbc_pkg::ST_LOOK: begin
        if (d_wb) begin
          state_next = lwbc_pkg::ST_WB;
        end else if (d_fill) begin
          state_next = lwbc_pkg::ST_FILL;
        end else begin
          state_next = lwbc_pkg::ST_STAT;
        end
      end
      lwbc_pkg::ST_WB: begin
        if (out_free) begin
          push       = 1'b1;
          push_kind  = lwbc_pkg::KIND_WB;
          push_blk   = r_wb_blk;
          state_next = r_fill ? lwbc_pkg::ST_FILL : lwbc_pkg::ST_STAT;
        end
      end
      lwbc_pkg::ST_FILL: begin
        if (out_free) begin
          push       = 1'b1;
          push_kind  = lwbc_pkg::KIND_FILL;
          state_next = lwbc_pkg::ST_STAT;
        end
      end
      lwbc_pkg::ST_STAT: begin
        if (out_free) begin
          push       = 1'b1;
          apply      = 1'b1;
          push_ok    = r_ok;
          push_last  = 1'b1;
          state_next = lwbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lwbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lwbc_pkg::ST_IDLE && s_axis_tvalid) begin
      req_op <= s_axis_tuser;
      req_id <= ID_BITS'(s_axis_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (state == lwbc_pkg::ST_LOOK) begin
      r_slot      <= d_slot;
      r_rank      <= d_rank;
      r_ctl       <= d_ctl;
      r_wb        <= d_wb;
      r_wb_blk    <= d_wb_blk;
      r_fill      <= d_fill;
      r_ok        <= d_ok;
      r_pop       <= d_pop;
      r_free_push <= d_free_push;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
    end else if (apply) begin
      if (r_pop) begin
        free_head <= c_head_link;
      end else if (r_free_push) begin
        free_head <= LINK_W'(r_slot);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind <= push_kind;
      out_slot <= push_slot;
      out_blk  <= push_blk;
      out_ok   <= push_ok;
      out_last <= push_last;
    end
  end

  assign m_axis_tdata = {3'b000, out_ok, out_blk, out_slot};
  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;

`ifndef SYNTHESIS
  a_free_pick_invalid: assert property (@(posedge clk) disable iff (rst)
    (state == lwbc_pkg::ST_LOOK && req_op == lwbc_pkg::OP_UPSERT && !c_flags.hit &&
     free_head < END_LINK) |-> !c_flags.head_valid)
    else $error("free list head names a valid slot");

  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    (state == lwbc_pkg::ST_LOOK && req_op == lwbc_pkg::OP_UPSERT && !c_flags.hit &&
     !free_ok) |-> c_flags.vic)
    else $error("no lru victim found with an empty free list");

  a_wb_state_needs_wb: assert property (@(posedge clk) disable iff (rst)
    (state == lwbc_pkg::ST_WB) |-> r_wb)
    else $error("writeback state entered without a writeback");

  a_apply_only_on_status: assert property (@(posedge clk) disable iff (rst)
    apply |=> (m_axis_tvalid && m_axis_tlast && state == lwbc_pkg::ST_IDLE))
    else $error("slot update not paired with the final status");
`endif

endmodule
